@@ design/assert_macros.svh @@
// Assertion macros shared by the instruction format decoder RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define SBID_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbid assertion failed");

// Checked on every rising edge, reset included.
`define SBID_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sbid assertion failed");

`endif

@@ design/sbid_pkg.sv @@
// Package for the instruction format decoder: format codes, result struct, range limits.
// No dependencies; used by the interfaces, the decode logic and the top level.
`default_nettype none

package sbid_pkg;

    // Format code carried on format_kind
    typedef enum logic [3:0] {
        FMT_MISC      = 4'd0,
        FMT_REG       = 4'd1,
        FMT_OPER      = 4'd2,
        FMT_REG_OPER  = 4'd3,
        FMT_TWO_OPER  = 4'd4,
        FMT_BRANCH    = 4'd5,
        FMT_SOB       = 4'd6,
        FMT_JMP       = 4'd7,
        FMT_JSR       = 4'd8,
        FMT_RESERVED  = 4'd9
    } t_format_kind;

    typedef logic [15:0] t_word;

    // One decoded item
    typedef struct packed {
        t_format_kind format_kind;
        logic [15:0]  opcode_bits;
        logic [2:0]   register_number;
        logic [5:0]   first_operand;
        logic [5:0]   second_operand;
        logic         branch_condition;
        logic [7:0]   branch_offset;
    } t_decode_result;

    // Misc group: whole-word ranges
    localparam logic [15:0] MISC_HALT_LO = 16'o000000;
    localparam logic [15:0] MISC_HALT_HI = 16'o000006;
    localparam logic [15:0] MISC_TRAP_LO = 16'o104000;
    localparam logic [15:0] MISC_TRAP_HI = 16'o104777;
    localparam logic [15:0] MISC_MARK_LO = 16'o006400;
    localparam logic [15:0] MISC_MARK_HI = 16'o006477;
    localparam logic [15:0] MISC_CC_LO   = 16'o000240;
    localparam logic [15:0] MISC_CC_HI   = 16'o000277;

    // Register group: bits 15..3
    localparam logic [12:0] REG_RTS = 13'o00020;
    localparam logic [12:0] REG_SPL = 13'o00023;

    // Single operand group: bits 15..6
    localparam logic [9:0] OPER_A_LO = 10'o0050;
    localparam logic [9:0] OPER_A_HI = 10'o0057;
    localparam logic [9:0] OPER_B_LO = 10'o1050;
    localparam logic [9:0] OPER_B_HI = 10'o1057;
    localparam logic [9:0] OPER_C_LO = 10'o0060;
    localparam logic [9:0] OPER_C_HI = 10'o0064;
    localparam logic [9:0] OPER_SXT  = 10'o0067;
    localparam logic [9:0] OPER_D_LO = 10'o1060;
    localparam logic [9:0] OPER_D_HI = 10'o1063;
    localparam logic [9:0] OPER_E_LO = 10'o0002;
    localparam logic [9:0] OPER_E_HI = 10'o0003;
    localparam logic [9:0] OPER_JMP  = 10'o0001;

    // Seven-bit opcode groups: bits 15..9
    localparam logic [6:0] RO_LO      = 7'o070;
    localparam logic [6:0] RO_HI      = 7'o074;
    localparam logic [6:0] BR_A_LO    = 7'o000;
    localparam logic [6:0] BR_A_HI    = 7'o003;
    localparam logic [6:0] BR_B_LO    = 7'o100;
    localparam logic [6:0] BR_B_HI    = 7'o103;
    localparam logic [6:0] OP7_SOB    = 7'o077;
    localparam logic [6:0] OP7_JSR    = 7'o004;

    // Double operand group: bits 15..12
    localparam logic [3:0] TWO_A_LO = 4'o01;
    localparam logic [3:0] TWO_A_HI = 4'o06;
    localparam logic [3:0] TWO_B_LO = 4'o11;
    localparam logic [3:0] TWO_B_HI = 4'o16;

endpackage

`default_nettype wire

@@ design/sbid_in_if.sv @@
// Input channel of the instruction format decoder: valid/ready plus one instruction word.
// Depends on sbid_pkg.
`default_nettype none

interface sbid_in_if;
    import sbid_pkg::*;

    logic  valid;
    logic  ready;
    t_word instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

`default_nettype wire

@@ design/sbid_out_if.sv @@
// Output channel of the instruction format decoder: valid/ready plus the decoded fields.
// Depends on sbid_pkg.
`default_nettype none

interface sbid_out_if;
    import sbid_pkg::*;

    logic         valid;
    logic         ready;
    t_format_kind format_kind;
    logic [15:0]  opcode_bits;
    logic [2:0]   register_number;
    logic [5:0]   first_operand;
    logic [5:0]   second_operand;
    logic         branch_condition;
    logic [7:0]   branch_offset;

    modport source (
        output valid, input ready,
        output format_kind, output opcode_bits, output register_number,
        output first_operand, output second_operand,
        output branch_condition, output branch_offset
    );
    modport sink (
        input valid, output ready,
        input format_kind, input opcode_bits, input register_number,
        input first_operand, input second_operand,
        input branch_condition, input branch_offset
    );
endinterface

`default_nettype wire

@@ design/sbid_decode.sv @@
// Combinational format classifier and field extractor for one instruction word.
// Depends on sbid_pkg.
`default_nettype none

module sbid_decode (
    input  sbid_pkg::t_word          i_word,
    output sbid_pkg::t_decode_result o_result
);
    import sbid_pkg::*;

    logic [12:0] top13;
    logic [9:0]  top10;
    logic [6:0]  top7;
    logic [3:0]  top4;
    logic        is_misc;
    logic        is_reg;
    logic        is_oper;
    logic        is_jmp;
    logic        is_reg_oper;
    logic        is_branch;
    logic        is_sob;
    logic        is_jsr;
    logic        is_two_oper;

    assign top13 = i_word[15:3];
    assign top10 = i_word[15:6];
    assign top7  = i_word[15:9];
    assign top4  = i_word[15:12];

    // Range matches, one per format group; ranges starting at zero need no lower bound
    always_comb begin
        is_misc = (i_word <= MISC_HALT_HI)
               || (i_word >= MISC_TRAP_LO && i_word <= MISC_TRAP_HI)
               || (i_word >= MISC_MARK_LO && i_word <= MISC_MARK_HI)
               || (i_word >= MISC_CC_LO   && i_word <= MISC_CC_HI);
        is_reg  = (top13 == REG_RTS) || (top13 == REG_SPL);
        is_oper = (top10 >= OPER_A_LO && top10 <= OPER_A_HI)
               || (top10 >= OPER_B_LO && top10 <= OPER_B_HI)
               || (top10 >= OPER_C_LO && top10 <= OPER_C_HI)
               || (top10 == OPER_SXT)
               || (top10 >= OPER_D_LO && top10 <= OPER_D_HI)
               || (top10 >= OPER_E_LO && top10 <= OPER_E_HI);
        is_jmp      = (top10 == OPER_JMP);
        is_reg_oper = (top7 >= RO_LO && top7 <= RO_HI);
        // Zero opcode with bit 8 clear is not a branch
        is_branch   = ((top7 <= BR_A_HI)
                    || (top7 >= BR_B_LO && top7 <= BR_B_HI))
                    && !(top7 == BR_A_LO && !i_word[8]);
        is_sob      = (top7 == OP7_SOB);
        is_jsr      = (top7 == OP7_JSR);
        is_two_oper = (top4 >= TWO_A_LO && top4 <= TWO_A_HI)
                   || (top4 >= TWO_B_LO && top4 <= TWO_B_HI);
    end

    // First match wins; unused fields stay zero
    always_comb begin
        o_result = '0;
        o_result.format_kind = FMT_RESERVED;
        priority if (is_misc) begin
            o_result.format_kind = FMT_MISC;
            o_result.opcode_bits = i_word;
        end else if (is_reg) begin
            o_result.format_kind     = FMT_REG;
            o_result.opcode_bits     = {3'b000, top13};
            o_result.register_number = i_word[2:0];
        end else if (is_oper) begin
            o_result.format_kind   = FMT_OPER;
            o_result.opcode_bits   = {6'b000000, top10};
            o_result.first_operand = i_word[5:0];
        end else if (is_jmp) begin
            o_result.format_kind   = FMT_JMP;
            o_result.opcode_bits   = {6'b000000, top10};
            o_result.first_operand = i_word[5:0];
        end else if (is_reg_oper) begin
            o_result.format_kind     = FMT_REG_OPER;
            o_result.opcode_bits     = {9'b000000000, top7};
            o_result.register_number = i_word[8:6];
            o_result.first_operand   = i_word[5:0];
        end else if (is_branch) begin
            o_result.format_kind      = FMT_BRANCH;
            o_result.opcode_bits      = {9'b000000000, top7};
            o_result.branch_condition = i_word[8];
            o_result.branch_offset    = i_word[7:0];
        end else if (is_sob) begin
            o_result.format_kind     = FMT_SOB;
            o_result.opcode_bits     = {9'b000000000, top7};
            o_result.register_number = i_word[8:6];
            o_result.branch_offset   = {2'b00, i_word[5:0]};
        end else if (is_jsr) begin
            o_result.format_kind     = FMT_JSR;
            o_result.opcode_bits     = {9'b000000000, top7};
            o_result.register_number = i_word[8:6];
            o_result.first_operand   = i_word[5:0];
        end else if (is_two_oper) begin
            o_result.format_kind    = FMT_TWO_OPER;
            o_result.opcode_bits    = {12'h000, top4};
            o_result.first_operand  = i_word[11:6];
            o_result.second_operand = i_word[5:0];
        end else begin
            o_result.format_kind = FMT_RESERVED;
        end
    end

endmodule

`default_nettype wire

@@ design/sixteen_bit_instruction_format_decoder_core.sv @@
// Instruction format decoder, top level: input register, decode logic, result register.
// Depends on sbid_pkg, sbid_in_if, sbid_out_if, sbid_decode and assert_macros.svh.
//
// Usage:
//   i_in  : valid/ready channel carrying one 16-bit instruction word per item.
//   o_out : valid/ready channel carrying one decoded item per input item: the
//           format code plus opcode, register, operand, condition and offset
//           fields; fields that the format does not use are zero.
//   Flow: an accepted item is held in the input register, decoded, then
//   moved into the result register, which drives o_out.
//   Throughput: one item per cycle, sustained, while o_out is taken; the
//   decode between the two registers is a single pass of range compares.
//   Stall: when o_out.ready is low the result register holds its item, the
//   input register holds the next one, and i_in.ready drops once both are
//   full; nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): both stages are emptied, o_out.valid
//   goes low and i_in.ready is high once reset has been applied.
//   There are no configuration registers and no state beyond the two stages.
`default_nettype none

module sixteen_bit_instruction_format_decoder_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    sbid_in_if.sink           i_in,
    sbid_out_if.source        o_out
);
    import sbid_pkg::*;

    logic           r_in_valid;
    logic           n_in_valid;
    t_word          r_word;
    logic           r_out_valid;
    logic           n_out_valid;
    t_decode_result r_out_result;
    t_decode_result w_result;
    logic           w_advance;
    logic           w_in_accept;

    // Pipeline control: the result stage frees when empty or taken
    assign w_advance   = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = i_in.ready ? i_in.valid : r_in_valid;
        n_out_valid = w_advance ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_word <= i_in.instruction_word;
        end
        if (w_advance && r_in_valid) begin
            r_out_result <= w_result;
        end
    end

    // Format decode between the two registers
    sbid_decode u_decode (
        .i_word   (r_word),
        .o_result (w_result)
    );

    // Output channel
    assign o_out.valid            = r_out_valid;
    assign o_out.format_kind      = r_out_result.format_kind;
    assign o_out.opcode_bits      = r_out_result.opcode_bits;
    assign o_out.register_number  = r_out_result.register_number;
    assign o_out.first_operand    = r_out_result.first_operand;
    assign o_out.second_operand   = r_out_result.second_operand;
    assign o_out.branch_condition = r_out_result.branch_condition;
    assign o_out.branch_offset    = r_out_result.branch_offset;

    // Checks
`include "assert_macros.svh"

    `SBID_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out.valid && !r_in_valid)
    `SBID_ASSERT(a_accept_fills_stage, i_clk, i_rst_n, w_in_accept |=> r_in_valid)
    `SBID_ASSERT(a_stage_moves_out, i_clk, i_rst_n,
        (r_in_valid && w_advance) |=> (o_out.valid && r_out_result == $past(w_result)))
    `SBID_ASSERT(a_reserved_zero, i_clk, i_rst_n,
        (o_out.valid && o_out.format_kind == FMT_RESERVED) |->
        (o_out.opcode_bits == 16'h0000 && o_out.register_number == 3'd0 &&
         o_out.first_operand == 6'd0 && o_out.branch_offset == 8'd0))
    `SBID_ASSERT(a_dest_only_two_oper, i_clk, i_rst_n,
        (o_out.valid && o_out.second_operand != 6'd0) |->
        (o_out.format_kind == FMT_TWO_OPER))

endmodule

`default_nettype wire

@@ tb/sv/sixteen_bit_instruction_format_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the instruction format decoder: corner words, then random words aimed at each format.
// Checks every decoded item against a local decoder. Depends on sbid_pkg, sbid_in_if, sbid_out_if and the core.

module sixteen_bit_instruction_format_decoder_core_tb;
    import sbid_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [10:0] RX_MASK      = 11'b10110011101;

    // Receiver behaviors
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_BURSTY
    } t_rx_mode;

    // One pending decode: the word and what it should decode to
    typedef struct {
        t_word          word;
        t_decode_result fields;
    } t_pending_decode;

    // Decodes accepted words and checks the results in order
    class decode_scoreboard;
        t_pending_decode pending_q[$];
        int unsigned     mismatches;
        int unsigned     words_seen;
        int unsigned     results_seen;
        int unsigned     format_hits[10];

        function t_decode_result decode_word(t_word w);
            logic [12:0]    top13;
            logic [9:0]     top10;
            logic [6:0]     top7;
            logic [3:0]     top4;
            t_decode_result r;
            top13 = w[15:3];
            top10 = w[15:6];
            top7  = w[15:9];
            top4  = w[15:12];
            r = '0;
            r.format_kind = FMT_RESERVED;
            // first matching group wins
            if (w <= MISC_HALT_HI || (w >= MISC_TRAP_LO && w <= MISC_TRAP_HI) ||
                (w >= MISC_MARK_LO && w <= MISC_MARK_HI) ||
                (w >= MISC_CC_LO && w <= MISC_CC_HI)) begin
                r.format_kind = FMT_MISC;
                r.opcode_bits = w;
            end else if (top13 == REG_RTS || top13 == REG_SPL) begin
                r.format_kind     = FMT_REG;
                r.opcode_bits     = {3'b000, top13};
                r.register_number = w[2:0];
            end else if ((top10 >= OPER_A_LO && top10 <= OPER_A_HI) ||
                         (top10 >= OPER_B_LO && top10 <= OPER_B_HI) ||
                         (top10 >= OPER_C_LO && top10 <= OPER_C_HI) ||
                         top10 == OPER_SXT ||
                         (top10 >= OPER_D_LO && top10 <= OPER_D_HI) ||
                         (top10 >= OPER_E_LO && top10 <= OPER_E_HI)) begin
                r.format_kind   = FMT_OPER;
                r.opcode_bits   = {6'b0, top10};
                r.first_operand = w[5:0];
            end else if (top10 == OPER_JMP) begin
                r.format_kind   = FMT_JMP;
                r.opcode_bits   = {6'b0, top10};
                r.first_operand = w[5:0];
            end else if (top7 >= RO_LO && top7 <= RO_HI) begin
                r.format_kind     = FMT_REG_OPER;
                r.opcode_bits     = {9'b0, top7};
                r.register_number = w[8:6];
                r.first_operand   = w[5:0];
            end else if ((top7 <= BR_A_HI || (top7 >= BR_B_LO && top7 <= BR_B_HI)) &&
                         !(top7 == BR_A_LO && !w[8])) begin
                // low zero group needs bit 8 set to be a branch
                r.format_kind      = FMT_BRANCH;
                r.opcode_bits      = {9'b0, top7};
                r.branch_condition = w[8];
                r.branch_offset    = w[7:0];
            end else if (top7 == OP7_SOB) begin
                r.format_kind     = FMT_SOB;
                r.opcode_bits     = {9'b0, top7};
                r.register_number = w[8:6];
                r.branch_offset   = {2'b00, w[5:0]};
            end else if (top7 == OP7_JSR) begin
                r.format_kind     = FMT_JSR;
                r.opcode_bits     = {9'b0, top7};
                r.register_number = w[8:6];
                r.first_operand   = w[5:0];
            end else if ((top4 >= TWO_A_LO && top4 <= TWO_A_HI) ||
                         (top4 >= TWO_B_LO && top4 <= TWO_B_HI)) begin
                r.format_kind    = FMT_TWO_OPER;
                r.opcode_bits    = {12'b0, top4};
                r.first_operand  = w[11:6];
                r.second_operand = w[5:0];
            end
            return r;
        endfunction

        function void note_word(t_word w);
            t_pending_decode p;
            p.word   = w;
            p.fields = decode_word(w);
            pending_q.push_back(p);
            words_seen++;
            format_hits[p.fields.format_kind]++;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_field(input string name, input logic [15:0] got,
                         input logic [15:0] want, input t_word w);
            if (got !== want)
                report_mismatch($sformatf("word %06o %s got 0x%0h want 0x%0h",
                                          w, name, got, want));
        endtask

        task check_result(input t_decode_result got);
            t_pending_decode p;
            results_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch("result with no word pending");
            end else begin
                p = pending_q.pop_front();
                check_field("format_kind", 16'(got.format_kind),
                            16'(p.fields.format_kind), p.word);
                check_field("opcode_bits", got.opcode_bits, p.fields.opcode_bits, p.word);
                check_field("register_number", 16'(got.register_number),
                            16'(p.fields.register_number), p.word);
                check_field("first_operand", 16'(got.first_operand),
                            16'(p.fields.first_operand), p.word);
                check_field("second_operand", 16'(got.second_operand),
                            16'(p.fields.second_operand), p.word);
                check_field("branch_condition", 16'(got.branch_condition),
                            16'(p.fields.branch_condition), p.word);
                check_field("branch_offset", 16'(got.branch_offset),
                            16'(p.fields.branch_offset), p.word);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycle_count = 0;
    t_rx_mode    rx_mode;
    logic        rx_level;
    int unsigned rx_hold;
    logic        tx_gappy;
    int unsigned burst_left;

    decode_scoreboard sb;

    // Corner words: range edges of every group plus the fall-through cases
    t_word corner_words[$] = '{
        16'o000000, 16'o000006, 16'o000007, 16'o177777, 16'o000200, 16'o000233,
        16'o000240, 16'o000277, 16'o000300, 16'o000100, 16'o005000, 16'o105777,
        16'o006700, 16'o104000, 16'o104777, 16'o006400, 16'o070000, 16'o074777,
        16'o077777, 16'o004567, 16'o000400, 16'o103777, 16'o010203, 16'o160000,
        16'o170000, 16'o075000
    };

    sbid_in_if  in_if ();
    sbid_out_if out_if ();

    sixteen_bit_instruction_format_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycle count and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still pending",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        case (rx_mode)
            RX_OPEN:    out_if.ready <= 1'b1;
            RX_RANDOM:  out_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: out_if.ready <= RX_MASK[cycle_count % 11];
            default: begin
                // alternate stretches of ready and stall, random lengths
                if (rx_hold == 0) begin
                    rx_level <= !rx_level;
                    rx_hold  <= $urandom_range(1, 12);
                end else begin
                    rx_hold <= rx_hold - 1;
                end
                out_if.ready <= rx_level;
            end
        endcase
    end

    // Watch both channels
    always @(posedge i_clk) begin : watch
        t_decode_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_word(in_if.instruction_word);
            if (out_if.valid && out_if.ready) begin
                got.format_kind      = out_if.format_kind;
                got.opcode_bits      = out_if.opcode_bits;
                got.register_number  = out_if.register_number;
                got.first_operand    = out_if.first_operand;
                got.second_operand   = out_if.second_operand;
                got.branch_condition = out_if.branch_condition;
                got.branch_offset    = out_if.branch_offset;
                sb.check_result(got);
            end
        end
    end

    // Random word aimed at one format, or fully random
    function automatic t_word pick_word();
        int unsigned pick;
        logic [9:0]  top10;
        logic [6:0]  top7;
        pick = $urandom_range(0, 10);
        if (pick > 9)
            return t_word'($urandom);
        case (t_format_kind'(pick))
            FMT_MISC: begin
                case ($urandom_range(0, 3))
                    0:       return t_word'($urandom_range(MISC_HALT_LO, MISC_HALT_HI));
                    1:       return t_word'($urandom_range(MISC_TRAP_LO, MISC_TRAP_HI));
                    2:       return t_word'($urandom_range(MISC_MARK_LO, MISC_MARK_HI));
                    default: return t_word'($urandom_range(MISC_CC_LO, MISC_CC_HI));
                endcase
            end
            FMT_REG:
                return {($urandom_range(0, 1) != 0) ? REG_SPL : REG_RTS, 3'($urandom)};
            FMT_OPER: begin
                case ($urandom_range(0, 5))
                    0:       top10 = 10'($urandom_range(OPER_A_LO, OPER_A_HI));
                    1:       top10 = 10'($urandom_range(OPER_B_LO, OPER_B_HI));
                    2:       top10 = 10'($urandom_range(OPER_C_LO, OPER_C_HI));
                    3:       top10 = OPER_SXT;
                    4:       top10 = 10'($urandom_range(OPER_D_LO, OPER_D_HI));
                    default: top10 = 10'($urandom_range(OPER_E_LO, OPER_E_HI));
                endcase
                return {top10, 6'($urandom)};
            end
            FMT_JMP:
                return {OPER_JMP, 6'($urandom)};
            FMT_REG_OPER:
                return {7'($urandom_range(RO_LO, RO_HI)), 9'($urandom)};
            FMT_BRANCH: begin
                if ($urandom_range(0, 1) != 0)
                    top7 = 7'($urandom_range(BR_A_LO, BR_A_HI));
                else
                    top7 = 7'($urandom_range(BR_B_LO, BR_B_HI));
                // mostly real branches; low zero group with bit 8 clear now and then
                if (top7 == BR_A_LO && $urandom_range(0, 3) != 0)
                    return {top7, 1'b1, 8'($urandom)};
                return {top7, 9'($urandom)};
            end
            FMT_SOB:
                return {OP7_SOB, 9'($urandom)};
            FMT_JSR:
                return {OP7_JSR, 9'($urandom)};
            FMT_TWO_OPER: begin
                if ($urandom_range(0, 1) != 0)
                    return {4'($urandom_range(TWO_A_LO, TWO_A_HI)), 12'($urandom)};
                return {4'($urandom_range(TWO_B_LO, TWO_B_HI)), 12'($urandom)};
            end
            default:
                return t_word'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input t_word w);
        in_if.valid            <= 1'b1;
        in_if.instruction_word <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        // sender idles between bursts
        if (tx_gappy) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_random(input int unsigned count, input logic gappy,
                               input t_rx_mode mode);
        tx_gappy = gappy;
        rx_mode <= mode;
        repeat (count) send_word(pick_word());
    endtask

    initial begin
        sb = new();
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.instruction_word = '0;
        out_if.ready           = 1'b0;
        rx_mode                = RX_OPEN;
        rx_level               = 1'b1;
        rx_hold                = 0;
        tx_gappy               = 1'b0;
        burst_left             = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner words under random stalls
        tx_gappy = 1'b1;
        rx_mode <= RX_RANDOM;
        foreach (corner_words[k]) send_word(corner_words[k]);

        // Random words through several idling mixes, two with no idling at all
        send_random(200, 1'b1, RX_BURSTY);
        send_random(150, 1'b0, RX_OPEN);
        send_random(150, 1'b0, RX_PATTERN);
        send_random(150, 1'b1, RX_RANDOM);
        in_if.valid <= 1'b0;

        // Drain
        rx_mode <= RX_OPEN;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (sb.pending() != 0)
            sb.report_mismatch($sformatf("word %06o never decoded",
                                         sb.pending_q.pop_front().word));

        $display("Decoded %0d words (%0d corner words first), %0d results checked",
                 sb.words_seen, corner_words.size(), sb.results_seen);
        $display("By format: misc %0d reg %0d oper %0d reg+oper %0d two %0d branch %0d",
                 sb.format_hits[FMT_MISC], sb.format_hits[FMT_REG],
                 sb.format_hits[FMT_OPER], sb.format_hits[FMT_REG_OPER],
                 sb.format_hits[FMT_TWO_OPER], sb.format_hits[FMT_BRANCH]);
        $display("           sob %0d jmp %0d jsr %0d reserved %0d, mismatches %0d",
                 sb.format_hits[FMT_SOB], sb.format_hits[FMT_JMP],
                 sb.format_hits[FMT_JSR], sb.format_hits[FMT_RESERVED], sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/sbid_pkg.sv
design/sbid_in_if.sv
design/sbid_out_if.sv
design/sbid_decode.sv
design/sixteen_bit_instruction_format_decoder_core.sv
tb/sv/sixteen_bit_instruction_format_decoder_core_tb.sv
